// ===== rtl/keyed_max_priority_table_top_assert.svh =====
// ----------------------------------------------------------------------------
// Keyed max priority table assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef KEYED_MAX_PRIORITY_TABLE_TOP_ASSERT_SVH
`define KEYED_MAX_PRIORITY_TABLE_TOP_ASSERT_SVH

// The condition holds at every clock edge outside reset.
`define KMPT_ASSERT_HOLDS(label, cond) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("kmpt: invariant violated");

// The consequent holds in the same cycle as the antecedent.
`define KMPT_ASSERT_IMPLIES(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("kmpt: same-cycle implication violated");

// The consequent holds in the cycle after the antecedent.
`define KMPT_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("kmpt: next-cycle implication violated");

`endif

// ===== rtl/kmpt_pkg.sv =====
// ----------------------------------------------------------------------------
// Keyed max priority table package
// Sizes, operation codes and the command and status bundles shared by the
// controller, the datapath and the top level.
// ----------------------------------------------------------------------------
package kmpt_pkg;

	// Table size and derived widths.
	localparam int CAPACITY = 16;
	localparam int IDX_W    = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);

	// Field widths.
	localparam int FUNC_W = 2;
	localparam int KEY_W  = 32;
	localparam int VAL_W  = 64;

	// Operation codes carried by a request.
	typedef enum logic [FUNC_W-1:0] {
		FUNC_INSERT = 2'd0,
		FUNC_REMOVE = 2'd1,
		FUNC_RANGE  = 2'd2
	} func_t;

	// Source of the table write data and address.
	typedef enum logic [1:0] {
		WR_UPDATE = 2'd0,
		WR_APPEND = 2'd1,
		WR_SHIFT  = 2'd2
	} wr_sel_t;

	// Source of a result.
	typedef enum logic [1:0] {
		SRC_FAIL  = 2'd0,
		SRC_INPUT = 2'd1,
		SRC_PEND  = 2'd2
	} src_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic    cap;
		logic    idx_clr;
		logic    idx_inc;
		logic    idx_best;
		logic    rd_en;
		logic    rd_next;
		logic    wr_en;
		wr_sel_t wr_sel;
		logic    cnt_inc;
		logic    cnt_dec;
		logic    pend_clr;
		logic    pend_load;
		logic    best_upd;
		logic    emit;
		src_t    emit_src;
		logic    emit_last;
	} kmpt_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic n_zero;
		logic n_full;
		logic idx_last;
		logic sh_more;
		logic key_eq;
		logic in_range;
		logic max_take;
		logic pend_valid;
		logic out_free;
	} kmpt_status_t;

endpackage

// ===== rtl/kmpt_ctrl.sv =====
// ----------------------------------------------------------------------------
// Keyed max priority table controller
// One-hot state machine that sequences the table scan, the append, the
// compaction after a removal and the delivery of results.
// ----------------------------------------------------------------------------
module kmpt_ctrl import kmpt_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [FUNC_W-1:0]   func,
	input  kmpt_status_t        status,
	output kmpt_cmd_t           cmd
);

	typedef enum logic [6:0] {
		S_IDLE   = 7'b0000001,
		S_RD     = 7'b0000010,
		S_CMP    = 7'b0000100,
		S_APPEND = 7'b0001000,
		S_SH_RD  = 7'b0010000,
		S_SH_WR  = 7'b0100000,
		S_EMIT   = 7'b1000000
	} state_t;

	state_t state_q, state_d;
	func_t  op_q, op_d;
	src_t   src_q, src_d;
	logic   last_q, last_d;
	logic   mid_q, mid_d;

	// Next state and commands.
	always_comb begin
		state_d  = state_q;
		op_d     = op_q;
		src_d    = src_q;
		last_d   = last_q;
		mid_d    = mid_q;
		cmd      = '0;
		in_ready = (state_q == S_IDLE);
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.cap      = 1'b1;
					cmd.idx_clr  = 1'b1;
					cmd.pend_clr = 1'b1;
					op_d         = func_t'(func);
					case (func_t'(func))
						FUNC_INSERT: begin
							state_d = status.n_zero ? S_APPEND : S_RD;
						end
						FUNC_REMOVE, FUNC_RANGE: begin
							if (status.n_zero) begin
								state_d = S_EMIT;
								src_d   = SRC_FAIL;
								last_d  = 1'b1;
								mid_d   = 1'b0;
							end else begin
								state_d = S_RD;
							end
						end
						default: begin
							state_d = S_EMIT;
							src_d   = SRC_FAIL;
							last_d  = 1'b1;
							mid_d   = 1'b0;
						end
					endcase
				end
			end
			S_RD: begin
				cmd.rd_en = 1'b1;
				state_d   = S_CMP;
			end
			S_CMP: begin
				case (op_q)
					FUNC_INSERT: begin
						if (status.key_eq) begin
							cmd.wr_en  = 1'b1;
							cmd.wr_sel = WR_UPDATE;
							state_d    = S_EMIT;
							src_d      = SRC_INPUT;
							last_d     = 1'b1;
							mid_d      = 1'b0;
						end else if (status.idx_last) begin
							if (status.n_full) begin
								state_d = S_EMIT;
								src_d   = SRC_FAIL;
								last_d  = 1'b1;
								mid_d   = 1'b0;
							end else begin
								state_d = S_APPEND;
							end
						end else begin
							cmd.idx_inc = 1'b1;
							state_d     = S_RD;
						end
					end
					FUNC_REMOVE: begin
						if (status.max_take) begin
							cmd.pend_load = 1'b1;
							cmd.best_upd  = 1'b1;
						end
						if (status.idx_last) begin
							cmd.idx_best = 1'b1;
							state_d      = S_SH_RD;
						end else begin
							cmd.idx_inc = 1'b1;
							state_d     = S_RD;
						end
					end
					FUNC_RANGE: begin
						if (status.in_range && status.pend_valid) begin
							// Older match goes out now; this one waits for the next.
							state_d = S_EMIT;
							src_d   = SRC_PEND;
							last_d  = 1'b0;
							mid_d   = 1'b1;
						end else begin
							if (status.in_range) begin
								cmd.pend_load = 1'b1;
							end
							if (status.idx_last) begin
								state_d = S_EMIT;
								mid_d   = 1'b0;
								last_d  = 1'b1;
								src_d   = (status.pend_valid || status.in_range) ?
								          SRC_PEND : SRC_FAIL;
							end else begin
								cmd.idx_inc = 1'b1;
								state_d     = S_RD;
							end
						end
					end
					default: begin
						state_d = S_IDLE;
					end
				endcase
			end
			S_APPEND: begin
				cmd.wr_en   = 1'b1;
				cmd.wr_sel  = WR_APPEND;
				cmd.cnt_inc = 1'b1;
				state_d     = S_EMIT;
				src_d       = SRC_INPUT;
				last_d      = 1'b1;
				mid_d       = 1'b0;
			end
			S_SH_RD: begin
				if (status.sh_more) begin
					cmd.rd_en   = 1'b1;
					cmd.rd_next = 1'b1;
					state_d     = S_SH_WR;
				end else begin
					cmd.cnt_dec = 1'b1;
					state_d     = S_EMIT;
					src_d       = SRC_PEND;
					last_d      = 1'b1;
					mid_d       = 1'b0;
				end
			end
			S_SH_WR: begin
				cmd.wr_en   = 1'b1;
				cmd.wr_sel  = WR_SHIFT;
				cmd.idx_inc = 1'b1;
				state_d     = S_SH_RD;
			end
			S_EMIT: begin
				if (status.out_free) begin
					cmd.emit      = 1'b1;
					cmd.emit_src  = src_q;
					cmd.emit_last = last_q;
					if (mid_q) begin
						// The entry under compare becomes the held match.
						cmd.pend_load = 1'b1;
						if (status.idx_last) begin
							src_d  = SRC_PEND;
							last_d = 1'b1;
							mid_d  = 1'b0;
						end else begin
							cmd.idx_inc = 1'b1;
							state_d     = S_RD;
						end
					end else begin
						state_d = S_IDLE;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// State registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			op_q    <= FUNC_INSERT;
			src_q   <= SRC_FAIL;
			last_q  <= 1'b0;
			mid_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			op_q    <= op_d;
			src_q   <= src_d;
			last_q  <= last_d;
			mid_q   <= mid_d;
		end
	end

endmodule

// ===== rtl/kmpt_dp.sv =====
// ----------------------------------------------------------------------------
// Keyed max priority table datapath
// Key and value memories, scan index, entry count, held match and the
// result register, all driven by controller commands.
// ----------------------------------------------------------------------------
module kmpt_dp import kmpt_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic signed [KEY_W-1:0] entry_key,
	input  logic [VAL_W-1:0]        entry_value,
	input  logic signed [KEY_W-1:0] range_low,
	input  logic signed [KEY_W-1:0] range_high,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic                    success,
	output logic signed [KEY_W-1:0] out_key,
	output logic [VAL_W-1:0]        out_value,
	output logic                    last,
	input  kmpt_cmd_t               cmd,
	output kmpt_status_t            status
);

	// Table memories.
	logic [KEY_W-1:0] key_mem [CAPACITY];
	logic [VAL_W-1:0] val_mem [CAPACITY];

	logic signed [KEY_W-1:0] key_q, lo_q, hi_q;
	logic [VAL_W-1:0]        val_q;
	logic signed [KEY_W-1:0] rd_key_q;
	logic [VAL_W-1:0]        rd_val_q;
	logic signed [KEY_W-1:0] pend_key_q;
	logic [VAL_W-1:0]        pend_val_q;
	logic                    pend_valid_q;
	logic [IDX_W-1:0]        idx_q, best_idx_q;
	logic [CNT_W-1:0]        cnt_q;
	logic                    out_valid_q;
	logic                    success_q, last_q;
	logic signed [KEY_W-1:0] out_key_q;
	logic [VAL_W-1:0]        out_val_q;

	logic [CNT_W-1:0] idx_nxt;
	logic [IDX_W-1:0] rd_addr, wr_addr;
	logic [KEY_W-1:0] wr_key;
	logic [VAL_W-1:0] wr_val;
	logic             out_free;

	// Scan position relative to the fill count.
	assign idx_nxt = CNT_W'(idx_q) + CNT_W'(1);
	assign rd_addr = cmd.rd_next ? idx_nxt[IDX_W-1:0] : idx_q;
	assign out_free = !out_valid_q || out_ready;

	// Write address and data selection.
	always_comb begin
		case (cmd.wr_sel)
			WR_UPDATE: begin
				wr_addr = idx_q;
				wr_key  = key_q;
				wr_val  = val_q;
			end
			WR_APPEND: begin
				wr_addr = cnt_q[IDX_W-1:0];
				wr_key  = key_q;
				wr_val  = val_q;
			end
			WR_SHIFT: begin
				wr_addr = idx_q;
				wr_key  = rd_key_q;
				wr_val  = rd_val_q;
			end
			default: begin
				wr_addr = idx_q;
				wr_key  = key_q;
				wr_val  = val_q;
			end
		endcase
	end

	// Memory write port and registered read port.
	always_ff @(posedge clk) begin
		if (cmd.wr_en) begin
			key_mem[wr_addr] <= wr_key;
			val_mem[wr_addr] <= wr_val;
		end
		if (cmd.rd_en) begin
			rd_key_q <= key_mem[rd_addr];
			rd_val_q <= val_mem[rd_addr];
		end
	end

	// Request fields, held match and best index.
	always_ff @(posedge clk) begin
		if (cmd.cap) begin
			key_q <= entry_key;
			val_q <= entry_value;
			lo_q  <= range_low;
			hi_q  <= range_high;
		end
		if (cmd.pend_load) begin
			pend_key_q <= rd_key_q;
			pend_val_q <= rd_val_q;
		end
		if (cmd.best_upd) begin
			best_idx_q <= idx_q;
		end
	end

	// Result payload.
	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			case (cmd.emit_src)
				SRC_INPUT: begin
					success_q <= 1'b1;
					out_key_q <= key_q;
					out_val_q <= val_q;
				end
				SRC_PEND: begin
					success_q <= 1'b1;
					out_key_q <= pend_key_q;
					out_val_q <= pend_val_q;
				end
				default: begin
					success_q <= 1'b0;
					out_key_q <= '0;
					out_val_q <= '0;
				end
			endcase
			last_q <= cmd.emit_last;
		end
	end

	// Control registers: scan index, fill count, match flag, result valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q        <= '0;
			cnt_q        <= '0;
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cmd.idx_clr) begin
				idx_q <= '0;
			end else if (cmd.idx_inc) begin
				idx_q <= idx_q + IDX_W'(1);
			end else if (cmd.idx_best) begin
				idx_q <= cmd.best_upd ? idx_q : best_idx_q;
			end
			if (cmd.cnt_inc) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (cmd.cnt_dec) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
			if (cmd.pend_clr) begin
				pend_valid_q <= 1'b0;
			end else if (cmd.pend_load) begin
				pend_valid_q <= 1'b1;
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Status toward the controller.
	always_comb begin
		status.n_zero     = (cnt_q == '0);
		status.n_full     = (cnt_q == CNT_W'(CAPACITY));
		status.idx_last   = (idx_nxt == cnt_q);
		status.sh_more    = (idx_nxt < cnt_q);
		status.key_eq     = (rd_key_q == key_q);
		status.in_range   = (rd_key_q >= lo_q) && (rd_key_q <= hi_q);
		status.max_take   = !pend_valid_q || (rd_key_q > pend_key_q);
		status.pend_valid = pend_valid_q;
		status.out_free   = out_free;
	end

	assign out_valid = out_valid_q;
	assign success   = success_q;
	assign out_key   = out_key_q;
	assign out_value = out_val_q;
	assign last      = last_q;

endmodule

// ===== rtl/keyed_max_priority_table_top.sv =====
// Requests are taken one at a time. Each scan step passes S_RD then S_CMP, each
// compaction step S_SH_RD then S_SH_WR, and a busy result register (output
// stall) holds the sequence in S_EMIT.
// Reset: asynchronous, active low; clears the state machine, the entry count
// and the result valid. Table memory contents are undefined after reset.
// ----------------------------------------------------------------------------
// Keyed max priority table top level
// Insertion-ordered key/value table with in-place update, max-key removal
// and range query, built from a controller and a memory-based datapath.
// ----------------------------------------------------------------------------
`include "keyed_max_priority_table_top_assert.svh"

module keyed_max_priority_table_top import kmpt_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic [FUNC_W-1:0]       func,
	input  logic signed [KEY_W-1:0] entry_key,
	input  logic [VAL_W-1:0]        entry_value,
	input  logic signed [KEY_W-1:0] range_low,
	input  logic signed [KEY_W-1:0] range_high,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic                    success,
	output logic signed [KEY_W-1:0] out_key,
	output logic [VAL_W-1:0]        out_value,
	output logic                    last
);

	kmpt_cmd_t    cmd;
	kmpt_status_t status;

	// Sequencer.
	kmpt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.func     (func),
		.status   (status),
		.cmd      (cmd)
	);

	// Table storage and result register.
	kmpt_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.entry_key   (entry_key),
		.entry_value (entry_value),
		.range_low   (range_low),
		.range_high  (range_high),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.success     (success),
		.out_key     (out_key),
		.out_value   (out_value),
		.last        (last),
		.cmd         (cmd),
		.status      (status)
	);

	// A result is only loaded when the result register can take it.
	`KMPT_ASSERT_IMPLIES(a_emit_slot_free, cmd.emit, status.out_free)
	// An append never happens on a full table.
	`KMPT_ASSERT_HOLDS(a_no_append_when_full, !(cmd.cnt_inc && status.n_full))
	// A removal never decrements an empty count.
	`KMPT_ASSERT_IMPLIES(a_dec_nonempty, cmd.cnt_dec, !status.n_zero)
	// One request is worked on at a time.
	`KMPT_ASSERT_NEXT(a_one_request, in_valid && in_ready, !in_ready)

endmodule

// ===== test/tb_keyed_max_priority_table_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Keyed max priority table testbench
// Feeds insert, remove-max, range and unused-code requests through the
// request channel, mirrors the table in a behavioral copy, and checks each
// result field by field in order. Sender gaps and receiver stalls vary by
// phase.
// ----------------------------------------------------------------------------
module tb_keyed_max_priority_table_top;
	import kmpt_pkg::*;

	localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_CYCLES = 100;
	localparam int PHASE_ITEMS = 26;

	localparam logic [KEY_W-1:0] KEY_MIN = 32'h8000_0000;
	localparam logic [KEY_W-1:0] KEY_MAX = 32'h7FFF_FFFF;

	// One request as presented on the input channel.
	typedef struct packed {
		logic [FUNC_W-1:0] op;
		logic [KEY_W-1:0]  key;
		logic [VAL_W-1:0]  value;
		logic [KEY_W-1:0]  lo;
		logic [KEY_W-1:0]  hi;
		logic              drain;
		logic [1:0]        phase;
	} request_t;

	// One result of the table.
	typedef struct packed {
		logic             ok;
		logic [KEY_W-1:0] key;
		logic [VAL_W-1:0] value;
		logic             fin;
	} table_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [FUNC_W-1:0] func = '0;
	logic signed [KEY_W-1:0] entry_key = '0;
	logic [VAL_W-1:0] entry_value = '0;
	logic signed [KEY_W-1:0] range_low = '0;
	logic signed [KEY_W-1:0] range_high = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic success;
	logic signed [KEY_W-1:0] out_key;
	logic [VAL_W-1:0] out_value;
	logic last;

	request_t pending_requests[$];
	table_result_t expected_results[$];
	request_t cur_req;
	bit req_taken = 1'b0;
	int idle_pct = 0;
	int stall_pct = 0;
	int mismatch_count = 0;
	int cycle_count = 0;

	// Behavioral copy of the table.
	logic signed [KEY_W-1:0] tbl_key [CAPACITY];
	logic [VAL_W-1:0] tbl_val [CAPACITY];
	int tbl_count = 0;

	keyed_max_priority_table_top u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.func(func),
		.entry_key(entry_key),
		.entry_value(entry_value),
		.range_low(range_low),
		.range_high(range_high),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.success(success),
		.out_key(out_key),
		.out_value(out_value),
		.last(last)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	// Update the table copy for one accepted request and queue its results.
	task automatic predict_table_op(input request_t r);
		table_result_t res;
		int hit;
		int best;
		int match_cnt;
		res = '{ok: 1'b0, key: '0, value: '0, fin: 1'b1};
		case (r.op)
			FUNC_INSERT: begin
				hit = -1;
				for (int i = 0; i < tbl_count; i++)
					if (hit < 0 && tbl_key[i] == $signed(r.key))
						hit = i;
				if (hit >= 0) begin
					tbl_val[hit] = r.value;
					res = '{ok: 1'b1, key: r.key, value: r.value, fin: 1'b1};
				end else if (tbl_count < CAPACITY) begin
					tbl_key[tbl_count] = r.key;
					tbl_val[tbl_count] = r.value;
					tbl_count++;
					res = '{ok: 1'b1, key: r.key, value: r.value, fin: 1'b1};
				end
				expected_results.push_back(res);
			end
			FUNC_REMOVE: begin
				if (tbl_count > 0) begin
					best = 0;
					for (int i = 1; i < tbl_count; i++)
						if (tbl_key[i] > tbl_key[best])
							best = i;
					res = '{ok: 1'b1, key: tbl_key[best], value: tbl_val[best], fin: 1'b1};
					for (int i = best; i + 1 < tbl_count; i++) begin
						tbl_key[i] = tbl_key[i + 1];
						tbl_val[i] = tbl_val[i + 1];
					end
					tbl_count--;
				end
				expected_results.push_back(res);
			end
			FUNC_RANGE: begin
				match_cnt = 0;
				for (int i = 0; i < tbl_count; i++) begin
					if (tbl_key[i] >= $signed(r.lo) && tbl_key[i] <= $signed(r.hi)) begin
						expected_results.push_back('{ok: 1'b1, key: tbl_key[i],
							value: tbl_val[i], fin: 1'b0});
						match_cnt++;
					end
				end
				// No match gives a single failed result; otherwise mark the final one.
				if (match_cnt == 0)
					expected_results.push_back(res);
				else
					expected_results[expected_results.size() - 1].fin = 1'b1;
			end
			default: begin
				expected_results.push_back(res);
			end
		endcase
	endtask

	task automatic add_request(input logic [FUNC_W-1:0] op, input logic [KEY_W-1:0] key,
			input logic [VAL_W-1:0] value, input logic [KEY_W-1:0] lo,
			input logic [KEY_W-1:0] hi, input logic drain, input logic [1:0] phase);
		request_t r;
		r = '{op: op, key: key, value: value, lo: lo, hi: hi, drain: drain, phase: phase};
		pending_requests.push_back(r);
	endtask

	// Keys mostly from a small pool so that updates and range hits are common.
	function automatic logic [KEY_W-1:0] pick_key();
		int sel;
		sel = $urandom_range(99);
		if (sel < 60)
			return $urandom_range(23) - 12;
		else if (sel < 75)
			case ($urandom_range(3))
				0: return KEY_MIN;
				1: return KEY_MAX;
				2: return '0;
				default: return '1;
			endcase
		else
			return $urandom;
	endfunction

	function automatic logic [VAL_W-1:0] pick_value();
		return {$urandom, $urandom};
	endfunction

	// Request source: directed opening, then random phases.
	initial begin
		logic [KEY_W-1:0] a;
		logic [KEY_W-1:0] b;
		logic [FUNC_W-1:0] op;
		int sel;

		// Empty table cases and the unused code.
		add_request(FUNC_REMOVE, '0, '0, '0, '0, 1'b0, 2'd0);
		add_request(FUNC_RANGE, '0, '0, KEY_MIN, KEY_MAX, 1'b0, 2'd0);
		add_request(FUNC_UNUSED, '1, '1, '1, '1, 1'b0, 2'd0);
		// Key extremes and value extremes.
		add_request(FUNC_INSERT, KEY_MIN, '0, '0, '0, 1'b0, 2'd0);
		add_request(FUNC_INSERT, KEY_MAX, '1, '0, '0, 1'b0, 2'd0);
		add_request(FUNC_INSERT, '0, pick_value(), '0, '0, 1'b0, 2'd0);
		add_request(FUNC_INSERT, '1, pick_value(), '0, '0, 1'b0, 2'd0);
		// Update in place, full range, inverted range.
		add_request(FUNC_INSERT, '0, pick_value(), '0, '0, 1'b0, 2'd0);
		add_request(FUNC_RANGE, '0, '0, KEY_MIN, KEY_MAX, 1'b0, 2'd0);
		add_request(FUNC_RANGE, '0, '0, 32'd5, -32'sd5, 1'b0, 2'd0);
		// Fill the table, then insert into a full table, new key and existing key.
		for (int i = 0; i < CAPACITY - 4; i++)
			add_request(FUNC_INSERT, 100 + 7 * i - 60 * (i % 2), pick_value(), '0, '0,
				1'b0, 2'd0);
		add_request(FUNC_INSERT, 32'd12345, pick_value(), '0, '0, 1'b0, 2'd0);
		add_request(FUNC_INSERT, KEY_MIN, pick_value(), '0, '0, 1'b0, 2'd0);
		add_request(FUNC_REMOVE, '0, '0, '0, '0, 1'b0, 2'd0);

		// Random phases: insert-heavy first half, remove-heavy second half.
		for (int p = 0; p < 4; p++) begin
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				sel = $urandom_range(99);
				if (i < PHASE_ITEMS / 2)
					op = (sel < 62) ? FUNC_INSERT : (sel < 78) ? FUNC_REMOVE :
						(sel < 96) ? FUNC_RANGE : FUNC_UNUSED;
				else
					op = (sel < 25) ? FUNC_INSERT : (sel < 68) ? FUNC_REMOVE :
						(sel < 96) ? FUNC_RANGE : FUNC_UNUSED;
				a = pick_key();
				b = pick_key();
				sel = $urandom_range(99);
				if (sel < 20) begin
					a = KEY_MIN;
					b = KEY_MAX;
				end else if (sel < 35) begin
					a = $urandom;
					b = $urandom;
				end else if (sel < 45) begin
					// Inverted bounds.
					if ($signed(a) < $signed(b)) begin
						a ^= b;
						b ^= a;
						a ^= b;
					end
				end else if ($signed(a) > $signed(b)) begin
					a ^= b;
					b ^= a;
					a ^= b;
				end
				add_request(op, pick_key(), pick_value(), a, b,
					(i == 0) || ($urandom_range(19) == 0), p[1:0]);
			end
		end

		// Reset is held, then released on a falling edge, away from the rising edge.
		arst_n = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (pending_requests.size() != 0 || in_valid || expected_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		mismatch_count += expected_results.size();
		if (mismatch_count == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

	// Request acceptance feeds the prediction.
	always @(posedge clk) begin
		if (arst_n && in_valid && in_ready) begin
			predict_table_op(cur_req);
			req_taken = 1'b1;
		end
	end

	// Driver: presents the next request when the channel is free.
	always @(negedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			out_ready <= 1'b0;
		end else begin
			if (pending_requests.size() != 0) begin
				case (pending_requests[0].phase)
					2'd0: begin idle_pct = 0;  stall_pct = 0;  end
					2'd1: begin idle_pct = 88; stall_pct = 0;  end
					2'd2: begin idle_pct = 0;  stall_pct = 88; end
					default: begin idle_pct = 17; stall_pct = 17; end
				endcase
			end
			out_ready <= ($urandom_range(99) >= stall_pct);
			if (!in_valid || req_taken) begin
				req_taken = 1'b0;
				// A drain request holds off until every result is back.
				if (pending_requests.size() != 0
						&& !(pending_requests[0].drain && expected_results.size() != 0)
						&& $urandom_range(99) >= idle_pct) begin
					cur_req = pending_requests.pop_front();
					in_valid <= 1'b1;
					func <= cur_req.op;
					entry_key <= cur_req.key;
					entry_value <= cur_req.value;
					range_low <= cur_req.lo;
					range_high <= cur_req.hi;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: compares each accepted result with the oldest expectation.
	always @(posedge clk) begin
		table_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_results.size() == 0) begin
				if (mismatch_count < 10)
					$display("%0t: unexpected result ok=%b key=%h value=%h last=%b",
						$realtime, success, out_key, out_value, last);
				mismatch_count++;
			end else begin
				want = expected_results.pop_front();
				if (success !== want.ok || out_key !== want.key
						|| out_value !== want.value || last !== want.fin) begin
					if (mismatch_count < 10) begin
						$display("%0t: mismatch expected ok=%b key=%h value=%h last=%b",
							$realtime, want.ok, want.key, want.value, want.fin);
						$display("    got ok=%b key=%h value=%h last=%b",
							success, out_key, out_value, last);
					end
					mismatch_count++;
				end
			end
		end
	end

	// Watchdog.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("FAILED: results differ");
			$finish;
		end
	end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/kmpt_pkg.sv
rtl/kmpt_ctrl.sv
rtl/kmpt_dp.sv
rtl/keyed_max_priority_table_top.sv
test/tb_keyed_max_priority_table_top.sv
